// File: rtl/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

   // Field widths of one transaction.
   localparam int YearBits  = 16;
   localparam int MonthBits = 4;
   localparam int DayBits   = 5;

   // Day numbers reach about 24 million for the largest year, so 25 bits hold them.
   localparam int DayNumBits = 25;
   // Quotient of a year (plus offset) by 100 stays below 1024.
   localparam int QuotBits   = 10;
   // Years are shifted by this amount to keep the day number positive.
   localparam int YearShift  = 400;

   // Reciprocal of 100 scaled by 2^24, rounded up; exact for operands below 2^17.
   localparam int             Div100Shift = 24;
   localparam logic [17:0]    Div100Mul   = 18'd167773;

   localparam int ReqDataBits = 56;
   localparam int RspDataBits = 24;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   // Month lengths of a common year, January first.
   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // One input transaction; the last field sits in the lowest bits.
   typedef struct packed {
      logic                 include_end_day;
      logic [DayBits-1:0]   end_day;
      logic [MonthBits-1:0] end_month;
      logic [YearBits-1:0]  end_year;
      logic [DayBits-1:0]   start_day;
      logic [MonthBits-1:0] start_month;
      logic [YearBits-1:0]  start_year;
   } gdd_req_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // load the input transaction
      logic div_year;    // divide the plain year by 100
      logic div_shift;   // divide the shifted year by 100
      logic accumulate;  // form the day number and check the date
      logic side;        // 0 selects the start date, 1 the end date
      logic finish;      // form the result into the output register
   } gdd_cmd_type;

   // Length of a month, zero for a month code outside 1 to 12.
   function automatic logic [4:0] month_days(input logic [MonthBits-1:0] month,
                                             input logic leap);
      logic [4:0] len;
      len = 5'd0;
      if (month >= 4'd1 && month <= 4'd12) begin
         if (month == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
         end else begin
            len = MONTH_LEN[4'(month - 4'd1)];
         end
      end
      return len;
   endfunction

   // Days before the first of a month in a year that starts in March.
   function automatic logic [8:0] month_offset(input logic [MonthBits-1:0] month);
      logic [8:0] ofs;
      case (month)
         4'd3:    ofs = 9'd0;
         4'd4:    ofs = 9'd31;
         4'd5:    ofs = 9'd61;
         4'd6:    ofs = 9'd92;
         4'd7:    ofs = 9'd122;
         4'd8:    ofs = 9'd153;
         4'd9:    ofs = 9'd184;
         4'd10:   ofs = 9'd214;
         4'd11:   ofs = 9'd245;
         4'd12:   ofs = 9'd275;
         4'd1:    ofs = 9'd306;
         4'd2:    ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

// File: rtl/gdd_ctrl.sv
`timescale 1ns / 1ps

module gdd_ctrl
   import gdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output gdd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_YEAR,
      ST_DIV_SHIFT,
      ST_ACCUM,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result once the old one leaves.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Command decode.
   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.div_year   = (state_ff == ST_DIV_YEAR);
      cmd.div_shift  = (state_ff == ST_DIV_SHIFT);
      cmd.accumulate = (state_ff == ST_ACCUM);
      cmd.side       = side_ff;
      cmd.finish     = (state_ff == ST_DONE) && out_free;
   end

   // Next state: three steps per date, start date first, then the result.
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      case (state_ff)
         ST_IDLE: begin
            side_in = 1'b0;
            if (req_tvalid) begin
               state_in = ST_DIV_YEAR;
            end
         end
         ST_DIV_YEAR:  state_in = ST_DIV_SHIFT;
         ST_DIV_SHIFT: state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (side_ff) begin
               state_in = ST_DONE;
            end else begin
               side_in  = 1'b1;
               state_in = ST_DIV_YEAR;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid: set when a result is formed, cleared when it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/gdd_datapath.sv
`timescale 1ns / 1ps

module gdd_datapath
   import gdd_pkg::*;
#(
   parameter logic [15:0] COUNT_MAX = 16'hFFFF
)
(
   input  logic                   clock,
   input  gdd_cmd_type            cmd,
   input  logic [ReqDataBits-1:0] req_tdata,
   output logic [15:0]            day_count,
   output logic [1:0]             status
);

   localparam int ProdBits = 17 + 18;
   localparam int WideBits = DayNumBits + 1;

   gdd_req_type                 req_ff, req_in;
   logic [QuotBits-1:0]         qy_ff, qy_in;
   logic [QuotBits-1:0]         qyy_ff, qyy_in;
   logic [DayNumBits-1:0]       dn_a_ff, dn_a_in;
   logic [DayNumBits-1:0]       dn_b_ff, dn_b_in;
   logic                        bad_ff, bad_in;
   logic [15:0]                 count_ff, count_in;
   logic [1:0]                  status_ff, status_in;

   logic [YearBits-1:0]         year;
   logic [MonthBits-1:0]        month;
   logic [DayBits-1:0]          day;
   logic [16:0]                 yy;
   logic [16:0]                 div_arg;
   logic [ProdBits-1:0]         prod;
   logic [16:0]                 qy_times100;
   logic                        leap;
   logic [4:0]                  mlen;
   logic                        date_bad;
   logic [WideBits-1:0]         dn_wide;
   logic [DayNumBits-1:0]       diff;
   logic [WideBits-1:0]         count_wide;

   // Select the date being worked on.
   always_comb begin
      year  = cmd.side ? req_ff.end_year  : req_ff.start_year;
      month = cmd.side ? req_ff.end_month : req_ff.start_month;
      day   = cmd.side ? req_ff.end_day   : req_ff.start_day;
   end

   // Shifted year; January and February count as the end of the year before.
   assign yy = {1'b0, year} + 17'(YearShift) - ((month <= 4'd2) ? 17'd1 : 17'd0);

   // Shared divide-by-100 unit: multiply by the scaled reciprocal.
   assign div_arg = cmd.div_shift ? yy : {1'b0, year};
   assign prod    = ProdBits'(div_arg) * ProdBits'(Div100Mul);

   // Leap rule of 4, 100 and 400 on the plain year.
   assign qy_times100 = 17'(qy_ff) * 17'd100;
   assign leap = (year[1:0] == 2'd0) &&
                 (({1'b0, year} != qy_times100) || (qy_ff[1:0] == 2'd0));

   // Date check.
   assign mlen     = month_days(month, leap);
   assign date_bad = (mlen == 5'd0) || (day == 5'd0) || (day > mlen);

   // Day number of the selected date.
   assign dn_wide = WideBits'(yy) * WideBits'(365)
                  + WideBits'(yy >> 2)
                  - WideBits'(qyy_ff)
                  + WideBits'(qyy_ff >> 2)
                  + WideBits'(month_offset(month))
                  + WideBits'(day);

   // Result: clamped difference, end-day increment and saturation.
   assign diff       = (dn_b_ff > dn_a_ff) ? (dn_b_ff - dn_a_ff) : '0;
   assign count_wide = WideBits'(diff) + WideBits'(req_ff.include_end_day);

   always_comb begin
      req_in    = cmd.capture ? gdd_req_type'(req_tdata[$bits(gdd_req_type)-1:0]) : req_ff;
      qy_in     = cmd.div_year  ? prod[Div100Shift +: QuotBits] : qy_ff;
      qyy_in    = cmd.div_shift ? prod[Div100Shift +: QuotBits] : qyy_ff;
      dn_a_in   = dn_a_ff;
      dn_b_in   = dn_b_ff;
      bad_in    = bad_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.accumulate) begin
         if (cmd.side) begin
            dn_b_in = dn_wide[DayNumBits-1:0];
            bad_in  = bad_ff | date_bad;
         end else begin
            dn_a_in = dn_wide[DayNumBits-1:0];
            bad_in  = date_bad;
         end
      end
      if (cmd.finish) begin
         if (bad_ff) begin
            count_in  = 16'd0;
            status_in = STATUS_INVALID;
         end else if (count_wide > WideBits'(COUNT_MAX)) begin
            count_in  = COUNT_MAX;
            status_in = STATUS_SATURATED;
         end else begin
            count_in  = count_wide[15:0];
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      qy_ff     <= qy_in;
      qyy_ff    <= qyy_in;
      dn_a_ff   <= dn_a_in;
      dn_b_ff   <= dn_b_in;
      bad_ff    <= bad_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign day_count = count_ff;
   assign status    = status_ff;

endmodule

// File: rtl/gregorian_date_difference.sv
`timescale 1ns / 1ps

// Channel  Direction  Data bits                                                 
// req_     in         tdata: start_year, start_month, start_day, end_year,
//                            end_month, end_day, include_end_day
// rsp_     out        tdata: day_count, status
//
// An item takes two divide-by-100 steps and one day-number step for each
// date on one shared reciprocal multiplier, one step to form the result and
// one idle step to accept; the next item is accepted only once the last is
// done. The result is formed only when no earlier result still waits in the
// output register.
// A held result does not block the next transaction; the controller only
// waits in its last step while the output register is still full.
// Reset is synchronous and clears the controller and the output valid.

module gregorian_date_difference
   import gdd_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // start_year[15:0], start_month[19:16], start_day[24:20], end_year[40:25],
   // end_month[44:41], end_day[49:45], include_end_day[50], zero fill
   input  logic [ReqDataBits-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // day_count[15:0], status[17:16], zero fill
   output logic [RspDataBits-1:0] rsp_tdata
);

   // Saturation limit, capped at the width of the count field.
   localparam logic [63:0] CountLimit = ((64'd1 << COUNT_BITS) - 64'd1) & 64'hFFFF;

   gdd_cmd_type cmd;
   logic [15:0] day_count;
   logic [1:0]  status;

   gdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   gdd_datapath #(
      .COUNT_MAX (CountLimit[15:0])
   ) u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .day_count (day_count),
      .status    (status)
   );

   assign rsp_tdata = {(RspDataBits - 18)'(0), status, day_count};

`ifndef SYNTHESIS
   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a transaction is in progress");

   // An invalid date reports a zero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status == STATUS_INVALID)) |-> (day_count == 16'd0))
      else $error("invalid date with nonzero count");

   // A saturated count sits at the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status == STATUS_SATURATED)) |-> (day_count == CountLimit[15:0]))
      else $error("saturated count below the limit");

   // A new result is only formed when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result formed over a pending one");
`endif

endmodule
